/* hdl/servo_command_frame_parser_top_defines.svh */
// Assertion macros shared by the servo command frame parser RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef SERVO_COMMAND_FRAME_PARSER_TOP_DEFINES_SVH
`define SERVO_COMMAND_FRAME_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define SCFP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("scfp assertion failed");
// Condition must never be seen outside reset.
`define SCFP_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("scfp forbidden condition seen");
`else
`define SCFP_ASSERT(lbl, clk, rst, prop)
`define SCFP_NEVER(lbl, clk, rst, cond)
`endif

`endif

/* hdl/scfp_pkg.sv */
// Shared types and constants for the servo command frame parser.
// No dependencies; used by all scfp modules and the top level.
`timescale 1ns / 1ps

package scfp_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned VAL_W        = 16;
  localparam int unsigned CHAN_W       = 3;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned KEPT_BYTES   = 4;
  localparam int unsigned CFG_INDEX_W  = 8;

  // Byte that arrives at this position closes the frame and is dropped.
  localparam logic [POS_W-1:0] BUFFER_LENGTH = 4'd10;

  localparam logic [BYTE_W-1:0] FRAME_END_CHAR = 8'h2F;  // '/'
  localparam logic [BYTE_W-1:0] ASCII_ZERO     = 8'h30;
  localparam logic [BYTE_W-1:0] LETTER_FIRST   = 8'h41;  // 'A'
  localparam logic [BYTE_W-1:0] LETTER_LAST    = 8'h46;  // 'F'

  localparam logic [CHAN_W-1:0] CHAN_B = 3'd1;
  localparam logic [CHAN_W-1:0] CHAN_F = 3'd5;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_ANGLE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_A     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_B     = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_F     = 8'd3;

  localparam logic [VAL_W-1:0] RESET_CENTER = 16'd130;
  localparam logic [VAL_W-1:0] RESET_OFF_A  = 16'd170;
  localparam logic [VAL_W-1:0] RESET_OFF_B  = 16'd150;
  localparam logic [VAL_W-1:0] RESET_OFF_F  = 16'd50;

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One parse job: selected channel plus the three angle digit bytes.
  typedef struct packed {
    logic [CHAN_W-1:0] channel;
    logic [BYTE_W-1:0] digit_hi;
    logic [BYTE_W-1:0] digit_mid;
    logic [BYTE_W-1:0] digit_lo;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

endpackage

/* hdl/scfp_front.sv */
// Front end: collects received bytes into a frame and classifies the frame
// at its end. Depends on scfp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "servo_command_frame_parser_top_defines.svh"

module scfp_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [scfp_pkg::BYTE_W-1:0]      rx_byte,
  output scfp_pkg::job_push_t              push
);

  logic [scfp_pkg::BYTE_W-1:0] frame_bytes [scfp_pkg::KEPT_BYTES];
  logic [scfp_pkg::BYTE_W-1:0] frame_bytes_next [scfp_pkg::KEPT_BYTES];
  logic [scfp_pkg::POS_W-1:0]  write_position;
  logic [scfp_pkg::POS_W-1:0]  write_position_next;
  logic                        buffer_full;
  logic                        frame_end;
  logic                        lead_is_letter;
  logic [scfp_pkg::BYTE_W-1:0] lead;

  assign buffer_full = (write_position >= scfp_pkg::BUFFER_LENGTH);

  always_comb begin
    for (int i = 0; i < scfp_pkg::KEPT_BYTES; i++) begin
      frame_bytes_next[i] = frame_bytes[i];
      if (accept && !buffer_full &&
          (write_position == scfp_pkg::POS_W'(i))) begin
        frame_bytes_next[i] = rx_byte;
      end
    end
  end

  // Overflow byte ends the frame unstored; '/' ends it after being stored.
  assign frame_end = accept && (buffer_full || (rx_byte == scfp_pkg::FRAME_END_CHAR));

  always_comb begin
    write_position_next = write_position;
    if (frame_end) begin
      write_position_next = '0;
    end else if (accept) begin
      write_position_next = write_position + 1'b1;
    end
  end

  assign lead           = frame_bytes_next[0];
  assign lead_is_letter = (lead >= scfp_pkg::LETTER_FIRST) &&
                          (lead <= scfp_pkg::LETTER_LAST);

  always_comb begin
    push.valid         = frame_end && lead_is_letter;
    push.job.channel   = scfp_pkg::CHAN_W'(lead - scfp_pkg::LETTER_FIRST);
    push.job.digit_hi  = frame_bytes_next[1];
    push.job.digit_mid = frame_bytes_next[2];
    push.job.digit_lo  = frame_bytes_next[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      for (int i = 0; i < scfp_pkg::KEPT_BYTES; i++) begin
        frame_bytes[i] <= '0;
      end
    end else begin
      write_position <= write_position_next;
      for (int i = 0; i < scfp_pkg::KEPT_BYTES; i++) begin
        frame_bytes[i] <= frame_bytes_next[i];
      end
    end
  end

  `SCFP_ASSERT(a_pos_in_range, clk, rst, write_position <= scfp_pkg::BUFFER_LENGTH)
  `SCFP_ASSERT(a_full_wraps, clk, rst, accept && buffer_full |=> write_position == '0)

endmodule

/* hdl/scfp_queue.sv */
// Short job queue between the frame front end and the compute back end.
// Depends on scfp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "servo_command_frame_parser_top_defines.svh"

module scfp_queue (
  input  logic                clk,
  input  logic                rst,
  input  scfp_pkg::job_push_t push,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output scfp_pkg::job_t      head
);

  scfp_pkg::job_t                   entries [scfp_pkg::QUEUE_DEPTH];
  logic [scfp_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [scfp_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [scfp_pkg::QUEUE_CNT_W-1:0] count;
  logic                             do_push;
  logic                             do_pop;

  localparam logic [scfp_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
    scfp_pkg::QUEUE_PTR_W'(scfp_pkg::QUEUE_DEPTH - 1);
  localparam logic [scfp_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
    scfp_pkg::QUEUE_CNT_W'(scfp_pkg::QUEUE_DEPTH);

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + scfp_pkg::QUEUE_CNT_W'(do_push) - scfp_pkg::QUEUE_CNT_W'(do_pop);
    end
  end

  `SCFP_NEVER(a_push_when_full, clk, rst, push.valid && full)
  `SCFP_NEVER(a_pop_when_empty, clk, rst, pop && empty)

endmodule

/* hdl/scfp_back.sv */
// Back end: holds the configuration registers, decodes the angle and forms
// the compare value in two registered stages. Depends on scfp_pkg and macros.
`timescale 1ns / 1ps
`include "servo_command_frame_parser_top_defines.svh"

module scfp_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [scfp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [scfp_pkg::VAL_W-1:0]         cfg_data,
  input  logic                               job_avail,
  input  scfp_pkg::job_t                     job,
  output logic                               job_take,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [scfp_pkg::CHAN_W-1:0]        channel,
  output logic [scfp_pkg::VAL_W-1:0]         angle,
  output logic [scfp_pkg::VAL_W-1:0]         compare_value
);

  logic [scfp_pkg::VAL_W-1:0]  center_angle;
  logic [scfp_pkg::VAL_W-1:0]  offset_a;
  logic [scfp_pkg::VAL_W-1:0]  offset_b;
  logic [scfp_pkg::VAL_W-1:0]  offset_f;

  logic                        s1_valid;
  logic [scfp_pkg::CHAN_W-1:0] s1_channel;
  logic [scfp_pkg::VAL_W-1:0]  s1_angle;
  logic                        s1_ready;
  logic                        out_ready;

  logic [scfp_pkg::VAL_W-1:0]  dig_hi;
  logic [scfp_pkg::VAL_W-1:0]  dig_mid;
  logic [scfp_pkg::VAL_W-1:0]  dig_lo;
  logic [scfp_pkg::VAL_W-1:0]  angle_calc;
  logic [scfp_pkg::VAL_W-1:0]  doubled;
  logic [scfp_pkg::VAL_W-1:0]  compare_calc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_angle <= scfp_pkg::RESET_CENTER;
      offset_a     <= scfp_pkg::RESET_OFF_A;
      offset_b     <= scfp_pkg::RESET_OFF_B;
      offset_f     <= scfp_pkg::RESET_OFF_F;
    end else if (cfg_write) begin
      unique case (cfg_index)
        scfp_pkg::CFG_CENTER_ANGLE: center_angle <= cfg_data;
        scfp_pkg::CFG_OFFSET_A:     offset_a     <= cfg_data;
        scfp_pkg::CFG_OFFSET_B:     offset_b     <= cfg_data;
        scfp_pkg::CFG_OFFSET_F:     offset_f     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_ready = !out_valid || !out_stall;
  assign s1_ready  = !s1_valid || out_ready;
  assign job_take  = job_avail && s1_ready;

  // Stage 1: digits are byte minus '0', wrapping at 16 bits.
  assign dig_hi  = {8'd0, job.digit_hi}  - {8'd0, scfp_pkg::ASCII_ZERO};
  assign dig_mid = {8'd0, job.digit_mid} - {8'd0, scfp_pkg::ASCII_ZERO};
  assign dig_lo  = {8'd0, job.digit_lo}  - {8'd0, scfp_pkg::ASCII_ZERO};
  assign angle_calc = scfp_pkg::VAL_W'(dig_hi * 16'd100) +
                      scfp_pkg::VAL_W'(dig_mid * 16'd10) + dig_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= job_take;
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      s1_channel <= job.channel;
      s1_angle   <= angle_calc;
    end
  end

  // Stage 2: compare value.
  assign doubled = scfp_pkg::VAL_W'((center_angle - s1_angle) << 1);

  always_comb begin
    priority if (s1_channel == scfp_pkg::CHAN_F) begin
      compare_calc = s1_angle + offset_f;
    end else if (s1_channel <= scfp_pkg::CHAN_B) begin
      compare_calc = doubled + offset_a;
    end else begin
      compare_calc = doubled + offset_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) begin
      channel       <= s1_channel;
      angle         <= s1_angle;
      compare_value <= compare_calc;
    end
  end

  `SCFP_ASSERT(a_out_channel_range, clk, rst, out_valid |-> channel <= scfp_pkg::CHAN_F)

endmodule

/* hdl/servo_command_frame_parser_top.sv */
// Top level of the servo command frame parser: front end, job queue and back end.
// Depends on scfp_pkg, scfp_front, scfp_queue, scfp_back and the macro header.
`timescale 1ns / 1ps

// Servo command frame parser. Feed received serial bytes one word per cycle on
// in_valid/in_stall/rx_byte. Bytes fill a frame buffer; a '/' (stored) or a
// byte arriving with BUFFER_LENGTH (10) bytes already in the frame (dropped)
// ends the frame and the position returns to zero. A frame whose first byte is
// 'A'..'F' yields one result word on out_valid/out_stall: the channel 0..5,
// the angle from bytes 1..3 as (b-'0') weighted 100/10/1, and the timer compare
// value, (center_angle - angle)*2 + offset_a (A, B) or offset_b (C..E), or
// angle + offset_f (F), all wrapping at 16 bits. Frame bytes not rewritten by a
// short frame keep their earlier values (zero after reset). Any other lead byte
// gives no result. Rate: one byte accepted every cycle while in_stall is low; a
// result passes the queue slot, angle stage and output register after its
// frame-ending byte is taken. in_stall rises only when the two-entry job queue
// is full, which happens only once out_stall has been held. Registers: index 0
// center_angle, 1 offset_a, 2 offset_b, 3 offset_f; cfg_ready is always high,
// writes to other indexes are ignored, and writes belong in idle periods.
module servo_command_frame_parser_top (
  input  logic                                clk,
  input  logic                                rst,
  // byte input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [scfp_pkg::BYTE_W-1:0]         rx_byte,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [scfp_pkg::CHAN_W-1:0]         channel,
  output logic [scfp_pkg::VAL_W-1:0]          angle,
  output logic [scfp_pkg::VAL_W-1:0]          compare_value,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [scfp_pkg::VAL_W-1:0]          cfg_data
);

  scfp_pkg::job_push_t push;
  scfp_pkg::job_t      head;
  logic                queue_full;
  logic                queue_empty;
  logic                job_take;
  logic                in_accept;

  // Front only pushes on an accepted word, so stalling on a full queue is enough.
  assign in_stall  = queue_full;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  scfp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .rx_byte (rx_byte),
    .push    (push)
  );

  scfp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (job_take),
    .full  (queue_full),
    .empty (queue_empty),
    .head  (head)
  );

  scfp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .job_avail     (!queue_empty),
    .job           (head),
    .job_take      (job_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel       (channel),
    .angle         (angle),
    .compare_value (compare_value)
  );

endmodule
